// ----- rtl/core/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// shared widths, payload structs and codes of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int CHANNEL_BITS  = 8;
	localparam int FRACTION_BITS = 16;
	// one integer quotient bit plus one guard bit below the kept fraction
	localparam int DIV_STEPS     = FRACTION_BITS + 2;
	// width of six times the spread
	localparam int HUE_W         = CHANNEL_BITS + 3;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FRACTION_BITS-1:0] hue;
		logic [FRACTION_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0]  brightness;
	} hsv_t;

	// channel that holds the maximum, red wins ties, then green
	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// side data that rides alongside the divider stages
	typedef struct packed {
		logic                    grey;
		logic [CHANNEL_BITS-1:0] hi;
	} side_t;

endpackage

// ----- rtl/core/rhc_divider.sv -----
// ----------------------------------------------------------------------------
// rhc_divider
// pipelined restoring divider, one quotient bit per stage, num <= den
// ----------------------------------------------------------------------------
module rhc_divider #(
	parameter int W     = 8,
	parameter int STEPS = 18
) (
	input  logic             clk,
	input  logic [STEPS-1:0] en,
	input  logic [W-1:0]     num,
	input  logic [W-1:0]     den,
	output logic [STEPS-1:0] quo
);

	logic [W-1:0]     rem_s [STEPS];
	logic [W-1:0]     den_s [STEPS];
	logic [STEPS-1:0] quo_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		logic [W:0]       rem_in;
		logic [W:0]       trial;
		logic [W-1:0]     den_in;
		logic [STEPS-1:0] quo_in;

		if (k == 0) begin : g_first
			// integer step, no shift
			assign rem_in = {1'b0, num};
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = {rem_s[k-1], 1'b0};
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = rem_in - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				if (!trial[W]) begin
					rem_s[k] <= trial[W-1:0];
					quo_s[k] <= {quo_in[STEPS-2:0], 1'b1};
				end else begin
					rem_s[k] <= rem_in[W-1:0];
					quo_s[k] <= {quo_in[STEPS-2:0], 1'b0};
				end
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = quo_s[STEPS-1];

endmodule

// ----- rtl/core/rgb_to_hsv_converter_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// streaming rgb to hsv conversion, fixed point, if the output does not stall, one pixel per clock
// ----------------------------------------------------------------------------
// usage:
//   pixel / pixel_valid / pixel_ready carry one rgb request per handshake,
//   hsv / hsv_valid / hsv_ready carry the matching hue, saturation and value.
//   a new pixel can be taken every cycle unless a low hsv_ready holds the full
//   pipe; sustained rate is one pixel per clock while hsv_ready stays high, set
//   by the fully pipelined datapath (no shared unit, no loop). an accepted pixel
//   passes 3 front stages (max/min, spread and sector difference, hue numerator),
//   18 divider stages (one quotient bit each, hue and saturation in parallel),
//   and the output register that rounds and clamps, before hsv_valid.
//   each stage advances when it is empty or the next stage advances, so
//   bubbles collapse and the block keeps taking pixels while a result waits.
//   when hsv_ready is low and the whole pipe is full, pixel_ready drops;
//   nothing is lost or repeated.
//   reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top
	import rhc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pixel_valid,
	output logic   pixel_ready,
	input  pixel_t pixel,
	output logic   hsv_valid,
	input  logic   hsv_ready,
	output hsv_t   hsv
);

	localparam int CB = CHANNEL_BITS;
	localparam int FB = FRACTION_BITS;

	// stage enables, each true when the stage may load
	logic                 en_s1, en_s2, en_s3, en_out;
	logic [DIV_STEPS-1:0] en_div;

	// stage 1: max, min and sector
	logic                   valid_s1;
	logic [CB-1:0]          red_s1, green_s1, blue_s1, hi_s1, lo_s1;
	sector_t                sector_s1;

	// stage 2: spread and signed channel difference
	logic                   valid_s2;
	logic [CB-1:0]          spread_s2, hi_s2;
	logic [CB:0]            diff_s2;
	sector_t                sector_s2;

	// stage 3: hue numerator and divisors
	logic                   valid_s3;
	logic [HUE_W-1:0]       num_s3, six_s3;
	logic [CB-1:0]          spread_s3, hi_s3;
	logic                   grey_s3;

	// divider side data and valids
	logic [DIV_STEPS-1:0]   div_valid_s;
	side_t                  side_s [DIV_STEPS];
	logic [DIV_STEPS-1:0]   hue_quo, sat_quo;

	// output register
	logic                   hsv_valid_q;
	hsv_t                   hsv_q;

	// ------------------------------------------------------------------
	// flow control: a stage loads when empty or when its successor loads
	// ------------------------------------------------------------------
	assign en_out = !hsv_valid_q || hsv_ready;

	always_comb begin
		en_div[DIV_STEPS-1] = !div_valid_s[DIV_STEPS-1] || en_out;
		for (int k = DIV_STEPS - 2; k >= 0; k--) begin
			en_div[k] = !div_valid_s[k] || en_div[k+1];
		end
	end

	assign en_s3       = !valid_s3 || en_div[0];
	assign en_s2       = !valid_s2 || en_s3;
	assign en_s1       = !valid_s1 || en_s2;
	assign pixel_ready = en_s1;

	// ------------------------------------------------------------------
	// stage 1: largest and smallest channel, red tested first
	// ------------------------------------------------------------------
	logic [CB-1:0] hi_c, lo_c;
	sector_t       sector_c;

	always_comb begin
		if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			sector_c = SEC_RED;
			hi_c     = pixel.red;
		end else if (pixel.green >= pixel.blue) begin
			sector_c = SEC_GREEN;
			hi_c     = pixel.green;
		end else begin
			sector_c = SEC_BLUE;
			hi_c     = pixel.blue;
		end
		lo_c = pixel.red;
		if (pixel.green < lo_c) lo_c = pixel.green;
		if (pixel.blue < lo_c)  lo_c = pixel.blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			red_s1    <= pixel.red;
			green_s1  <= pixel.green;
			blue_s1   <= pixel.blue;
			hi_s1     <= hi_c;
			lo_s1     <= lo_c;
			sector_s1 <= sector_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: spread and the difference of the other two channels
	// ------------------------------------------------------------------
	logic [CB:0] diff_c;

	always_comb begin
		case (sector_s1)
			SEC_RED:   diff_c = {1'b0, green_s1} - {1'b0, blue_s1};
			SEC_GREEN: diff_c = {1'b0, blue_s1} - {1'b0, red_s1};
			SEC_BLUE:  diff_c = {1'b0, red_s1} - {1'b0, green_s1};
			default:   diff_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			spread_s2 <= hi_s1 - lo_s1;
			hi_s2     <= hi_s1;
			diff_s2   <= diff_c;
			sector_s2 <= sector_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: hue numerator in [0, 6*spread), modulo the numerator width
	// ------------------------------------------------------------------
	logic [HUE_W-1:0] spread_w, six_c, diff_w, num_c;

	assign spread_w = {3'b000, spread_s2};
	assign six_c    = (spread_w << 2) + (spread_w << 1);
	assign diff_w   = {{2{diff_s2[CB]}}, diff_s2};

	always_comb begin
		case (sector_s2)
			// red sector wraps a negative difference into one turn
			SEC_RED:   num_c = diff_s2[CB] ? six_c + diff_w : diff_w;
			SEC_GREEN: num_c = (spread_w << 1) + diff_w;
			SEC_BLUE:  num_c = (spread_w << 2) + diff_w;
			default:   num_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			num_s3    <= num_c;
			six_s3    <= six_c;
			spread_s3 <= spread_s2;
			hi_s3     <= hi_s2;
			grey_s3   <= (spread_s2 == '0);
		end
	end

	// ------------------------------------------------------------------
	// dividers: hue = num / (6*spread), saturation = spread / max
	// a grey pixel divides by zero here and is overridden at the output
	// ------------------------------------------------------------------
	rhc_divider #(
		.W     (HUE_W),
		.STEPS (DIV_STEPS)
	) u_hue_div (
		.clk (clk),
		.en  (en_div),
		.num (num_s3),
		.den (six_s3),
		.quo (hue_quo)
	);

	rhc_divider #(
		.W     (CB),
		.STEPS (DIV_STEPS)
	) u_sat_div (
		.clk (clk),
		.en  (en_div),
		.num (spread_s3),
		.den (hi_s3),
		.quo (sat_quo)
	);

	// valid bits and side data move in step with the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_s <= '0;
		end else begin
			if (en_div[0]) div_valid_s[0] <= valid_s3;
			for (int k = 1; k < DIV_STEPS; k++) begin
				if (en_div[k]) div_valid_s[k] <= div_valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_div[0]) begin
			side_s[0].grey <= grey_s3;
			side_s[0].hi   <= hi_s3;
		end
		for (int k = 1; k < DIV_STEPS; k++) begin
			if (en_div[k]) side_s[k] <= side_s[k-1];
		end
	end

	// ------------------------------------------------------------------
	// output: round half up by dropping the guard bit, clamp saturation
	// ------------------------------------------------------------------
	logic [DIV_STEPS-1:0] hue_rnd, sat_rnd;
	side_t                side_last;

	assign hue_rnd   = hue_quo + DIV_STEPS'(1);
	assign sat_rnd   = sat_quo + DIV_STEPS'(1);
	assign side_last = side_s[DIV_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid_q <= 1'b0;
		end else if (en_out) begin
			hsv_valid_q <= div_valid_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			hsv_q.brightness <= side_last.hi;
			if (side_last.grey) begin
				hsv_q.hue        <= '0;
				hsv_q.saturation <= '0;
			end else begin
				// a hue that rounds to a full turn wraps to zero
				hsv_q.hue <= hue_rnd[DIV_STEPS-2:1];
				// a saturation that rounds to one clamps to all ones
				hsv_q.saturation <= sat_rnd[DIV_STEPS-1] ? {FB{1'b1}}
				                                         : sat_rnd[DIV_STEPS-2:1];
			end
		end
	end

	assign hsv_valid = hsv_valid_q;
	assign hsv       = hsv_q;

`ifndef SYNTHESIS
	// hue numerator is always below its divisor, so no integer quotient bit
	a_hue_below_turn: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_s[DIV_STEPS-1] && !side_last.grey |-> !hue_quo[DIV_STEPS-1])
		else $error("hue quotient reached a full turn");

	// saturation quotient never exceeds exactly one
	a_sat_at_most_one: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid_s[DIV_STEPS-1] && !side_last.grey && sat_quo[DIV_STEPS-1]
		|-> sat_quo[DIV_STEPS-2:0] == '0)
		else $error("saturation quotient above one");

	// black pixel has no hue and no saturation
	a_black_is_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.brightness == '0 |-> hsv.hue == '0 && hsv.saturation == '0)
		else $error("black pixel with nonzero hue or saturation");

	// zero saturation only comes from a grey pixel, which has zero hue
	a_unsat_no_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.saturation == '0 |-> hsv.hue == '0)
		else $error("hue set on an unsaturated pixel");
`endif

endmodule

// ----- verif/rgb_to_hsv_converter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top_tb
// self-checking testbench of the streaming rgb to hsv converter
// ----------------------------------------------------------------------------
// pixels go in through the valid/ready request channel and every accepted
// request gets its hue, saturation and value worked out by a fixed point
// model inside this file. results coming out are checked in order against
// those expectations. both sides idle at random, and one test holds the
// output off long enough for the pipeline to fill and stall the input.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top_tb;
	import rhc_pkg::*;

	localparam int     CLK_HALF      = 5;
	localparam int     RESET_CYCLES  = 8;
	// the pipe is 22 deep, so this lets it drain with margin
	localparam int     DRAIN_CYCLES  = 40;
	// longest quiet stretch allowed, well above the long output stall
	localparam int     WATCHDOG_MAX  = 2000;
	localparam int     RANDOM_ITEMS  = 550;
	localparam int     IDLE_PERCENT  = 18;
	localparam int     MAX_REPORTS   = 10;
	localparam longint FRAC_MAX      = (longint'(1) << FRACTION_BITS) - 1;
	localparam int     CHAN_MAX      = (1 << CHANNEL_BITS) - 1;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   pixel_valid = 1'b0;
	logic   pixel_ready;
	pixel_t pixel       = '0;
	logic   hsv_valid;
	logic   hsv_ready   = 1'b0;
	hsv_t   hsv;

	// hsv results still owed by the block, oldest first
	hsv_t expected_hsv_q[$];

	int mismatch_count = 0;
	int error_count    = 0;
	int quiet_cycles   = 0;
	// output hold-off, counted down by the receiver process
	int stall_left     = 0;
	// random idling on both sides, switched off for stretches
	bit idle_on        = 1'b1;

	rgb_to_hsv_converter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.hsv_valid   (hsv_valid),
		.hsv_ready   (hsv_ready),
		.hsv         (hsv)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// fixed point rgb to hsv: value is the max channel, saturation is
	// spread over max, hue follows the sector of the max channel with red
	// winning ties over green and green over blue; all rounded halves up
	function automatic hsv_t predict_hsv(pixel_t p);
		longint r, g, b, hi, lo, spread, num, six, hue_q, sat_q;
		hsv_t   res;
		r = longint'(p.red);
		g = longint'(p.green);
		b = longint'(p.blue);
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		spread = hi - lo;
		hue_q = 0;
		sat_q = 0;
		// grey pixel: hue and saturation stay zero
		if (spread != 0) begin
			if (r == hi)
				num = g - b;
			else if (g == hi)
				num = 2 * spread + (b - r);
			else
				num = 4 * spread + (r - g);
			// negative angle wraps into one turn
			if (num < 0)
				num = num + 6 * spread;
			six = 6 * spread;
			// a hue rounding to a full turn wraps to zero through the mask
			hue_q = (((num << (FRACTION_BITS + 1)) + six) / (six * 2)) & FRAC_MAX;
			sat_q = ((spread << (FRACTION_BITS + 1)) + hi) / (hi * 2);
			// full saturation clamps to the largest fraction
			if (sat_q > FRAC_MAX)
				sat_q = FRAC_MAX;
		end
		res.hue        = hue_q[FRACTION_BITS-1:0];
		res.saturation = sat_q[FRACTION_BITS-1:0];
		res.brightness = hi[CHANNEL_BITS-1:0];
		return res;
	endfunction

	// offer one pixel request, with a random gap before it, and book the
	// expected result once the block takes it
	task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
		input logic [CHANNEL_BITS-1:0] g, input logic [CHANNEL_BITS-1:0] b);
		pixel_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
		expected_hsv_q.push_back(predict_hsv(p));
	endtask

	function automatic logic [CHANNEL_BITS-1:0] rand_chan();
		return CHANNEL_BITS'($urandom_range(CHAN_MAX));
	endfunction

	// corners of the color cube, ties between maxima, greys, the smallest
	// spreads and hues right below a full turn
	task automatic test_directed();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		send_pixel(8'hff, 8'hff, 8'h00);
		send_pixel(8'h00, 8'hff, 8'hff);
		send_pixel(8'hff, 8'h00, 8'hff);
		// red and green share the max, red must win
		send_pixel(8'hc8, 8'hc8, 8'h32);
		// green and blue share the max, green must win
		send_pixel(8'h0a, 8'hc8, 8'hc8);
		// red and blue share the max, red must win
		send_pixel(8'hc8, 8'h0a, 8'hc8);
		// max of one, min of zero
		send_pixel(8'h01, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h01);
		// spread of one at the top of the range
		send_pixel(8'hff, 8'hfe, 8'hfe);
		send_pixel(8'hfe, 8'hff, 8'hfe);
		// red max with blue just above green: hue just under a full turn
		send_pixel(8'hff, 8'h00, 8'h01);
		send_pixel(8'h02, 8'h00, 8'h01);
		// alternating bit patterns
		send_pixel(8'haa, 8'h55, 8'hcc);
		send_pixel(8'h55, 8'haa, 8'h33);
		send_pixel(8'h33, 8'hcc, 8'haa);
	endtask

	// mostly uniform pixels, plus greys, tied maxima, a zero channel and
	// tiny values; items 300 to 399 run without any idling
	task automatic test_random();
		logic [CHANNEL_BITS-1:0] r, g, b;
		int                      shape;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idle_on = !(i >= 300 && i < 400);
			r = rand_chan();
			g = rand_chan();
			b = rand_chan();
			shape = $urandom_range(9);
			case (shape)
				0: begin
					g = r;
					b = r;
				end
				1: begin
					if (g > r) r = g;
					g = r;
				end
				2: begin
					if (b > g) g = b;
					b = g;
				end
				3: begin
					if ($urandom_range(1)) r = '0;
					else g = '0;
				end
				4: begin
					r = CHANNEL_BITS'($urandom_range(3));
					g = CHANNEL_BITS'($urandom_range(3));
					b = CHANNEL_BITS'($urandom_range(3));
				end
				default: begin
				end
			endcase
			send_pixel(r, g, b);
		end
		idle_on = 1'b1;
	endtask

	// hold the output off while requests keep coming, so the pipe fills
	// and pixel_ready has to drop
	task automatic test_output_stall();
		idle_on    = 1'b0;
		stall_left = 200;
		for (int i = 0; i < 80; i++)
			send_pixel(rand_chan(), rand_chan(), rand_chan());
		idle_on = 1'b1;
	endtask

	// receiver side: long hold-off first, else random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			hsv_ready <= 1'b0;
		end else if (stall_left > 0) begin
			hsv_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			hsv_ready <= 1'b0;
		end else begin
			hsv_ready <= 1'b1;
		end
	end

	// result checker: each result against the oldest expectation
	always @(posedge clk) begin
		hsv_t want;
		if (arst_n && hsv_valid && hsv_ready) begin
			if (expected_hsv_q.size() == 0) begin
				error_count++;
				$display("error: result with nothing expected, hue %0d sat %0d val %0d",
					hsv.hue, hsv.saturation, hsv.brightness);
			end else begin
				want = expected_hsv_q.pop_front();
				if (hsv.hue !== want.hue || hsv.saturation !== want.saturation ||
					hsv.brightness !== want.brightness) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
							want.hue, want.saturation, want.brightness,
							hsv.hue, hsv.saturation, hsv.brightness);
				end
			end
		end
	end

	// watchdog on cycles in which neither channel moves a request
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_output_stall();
		// stop offering and let everything owed come out
		pixel_valid <= 1'b0;
		while (expected_hsv_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && error_count == 0 && expected_hsv_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
